[hdl/ssd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the shift-subtract divider
// Holds the request and result transfer types, the operation codes and the
// sign and mode flags passed from operand preparation to the top level.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Operation codes: bit 0 selects the 32-bit mode, bit 1 the signed mode.
    localparam logic [1:0] OP_UNSIGNED_WIDE   = 2'd0;
    localparam logic [1:0] OP_UNSIGNED_NARROW = 2'd1;
    localparam logic [1:0] OP_SIGNED_WIDE     = 2'd2;
    localparam logic [1:0] OP_SIGNED_NARROW   = 2'd3;

    // Width of the 32-bit modes.
    localparam int NARROW_BITS = 32;

    // One request transfer.
    typedef struct packed {
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [1:0]  opcode;
    } request_t;

    // One result transfer.
    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic        divide_by_zero;
    } result_t;

    // Mode and sign information that follows an operation through the core.
    typedef struct packed {
        logic narrow;
        logic rem_neg;
        logic quo_neg;
        logic div_zero;
    } sign_flags_t;

endpackage

[hdl/ssd_operand_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_operand_prep: operand masking and magnitude conversion
// Cuts both operands to the operation width, takes magnitudes in the signed
// modes and derives the sign fixups and the divide-by-zero flag.
// ----------------------------------------------------------------------------
module ssd_operand_prep #(
    parameter int WORD_BITS = 64
) (
    input  ssd_pkg::request_t      request,
    output logic [WORD_BITS-1:0]   dividend_mag,
    output logic [WORD_BITS-1:0]   divisor_mag,
    output ssd_pkg::sign_flags_t   flags
);

    logic                 narrow;
    logic                 is_signed;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] n_masked;
    logic [WORD_BITS-1:0] d_masked;
    logic                 n_neg;
    logic                 d_neg;
    logic [WORD_BITS-1:0] n_negated;
    logic [WORD_BITS-1:0] d_negated;

    // Decode the operation and mask the operands to its width.
    always_comb
    begin
        narrow    = request.opcode[0];
        is_signed = request.opcode[1];
        mask      = narrow ? WORD_BITS'({ssd_pkg::NARROW_BITS{1'b1}}) : '1;
        n_masked  = request.dividend[WORD_BITS-1:0] & mask;
        d_masked  = request.divisor[WORD_BITS-1:0] & mask;
    end

    // Sign bits sit at bit 31 in the 32-bit modes and at the top otherwise.
    always_comb
    begin
        if (narrow)
        begin
            n_neg = is_signed & n_masked[ssd_pkg::NARROW_BITS-1];
            d_neg = is_signed & d_masked[ssd_pkg::NARROW_BITS-1];
        end
        else
        begin
            n_neg = is_signed & n_masked[WORD_BITS-1];
            d_neg = is_signed & d_masked[WORD_BITS-1];
        end
    end

    // Magnitudes of negative operands, kept within the operation width.
    always_comb
    begin
        n_negated    = (WORD_BITS'(0) - n_masked) & mask;
        d_negated    = (WORD_BITS'(0) - d_masked) & mask;
        dividend_mag = n_neg ? n_negated : n_masked;
        divisor_mag  = d_neg ? d_negated : d_masked;
    end

    // The quotient is negative when the signs differ; the remainder follows
    // the dividend.
    always_comb
    begin
        flags.narrow   = narrow;
        flags.rem_neg  = n_neg;
        flags.quo_neg  = n_neg ^ d_neg;
        flags.div_zero = (d_masked == '0);
    end

endmodule

[hdl/ssd_shift_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_shift_core: restoring shift-subtract division core
// Shifts one dividend bit per cycle into the partial remainder and one
// quotient bit per cycle into the freed low end of the dividend register.
// ----------------------------------------------------------------------------
module ssd_shift_core #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 running,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [CNT_BITS-1:0]  step_cnt_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] quo_next;
    logic [WORD_BITS-1:0] dvs_reg;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    // Step counter: one quotient bit per cycle, WORD_BITS steps in all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (load)
        begin
            step_cnt_reg <= CNT_BITS'(WORD_BITS);
        end
        else if (step_cnt_reg != '0)
        begin
            step_cnt_reg <= step_cnt_reg - CNT_BITS'(1);
        end
    end

    // Trial subtraction of the divisor from the shifted partial remainder.
    // The partial remainder stays below the divisor, so a restored value
    // still fits in WORD_BITS bits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[WORD_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[WORD_BITS])
        begin
            rem_next = diff[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (step_cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign running   = (step_cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/shift_subtract_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_subtract_divider: signed and unsigned integer divider
// Restoring radix-2 division in 64-bit or 32-bit, signed or unsigned modes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  request   in         start and !busy  dividend, divisor, opcode
//  result    out        done (1 cycle)   quotient, remainder, divide_by_zero
//
//  An operation passes from the accepting edge through the core iterations,
//  one quotient bit per core cycle, then a sequencer state that sees the
//  core finish and the fixup state for the signs, at whose end the result
//  and done are registered. A zero divisor skips the core and goes straight
//  to the fixup state. busy is high until the result is driven, and the
//  receiver cannot stall. Reset clears the sequencer and the done strobe.
// ----------------------------------------------------------------------------
module shift_subtract_divider #(
    parameter int WORD_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ssd_pkg::request_t   request,
    output logic                done,
    output ssd_pkg::result_t    result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic                     accept;
    logic [WORD_BITS-1:0]     dividend_mag;
    logic [WORD_BITS-1:0]     divisor_mag;
    ssd_pkg::sign_flags_t     prep_flags;
    ssd_pkg::sign_flags_t     flags_reg;
    logic                     core_running;
    logic [WORD_BITS-1:0]     core_quotient;
    logic [WORD_BITS-1:0]     core_remainder;
    logic [WORD_BITS-1:0]     mask;
    logic [WORD_BITS-1:0]     quo_fixed;
    logic [WORD_BITS-1:0]     rem_fixed;
    logic                     done_reg;
    ssd_pkg::result_t         result_reg;

    assign accept = start && (state_reg == ST_IDLE);

    ssd_operand_prep #(
        .WORD_BITS (WORD_BITS)
    ) u_prep (
        .request      (request),
        .dividend_mag (dividend_mag),
        .divisor_mag  (divisor_mag),
        .flags        (prep_flags)
    );

    ssd_shift_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && !prep_flags.div_zero),
        .dividend  (dividend_mag),
        .divisor   (divisor_mag),
        .running   (core_running),
        .quotient  (core_quotient),
        .remainder (core_remainder)
    );

    // Sequencer: idle, core iterations, result fixup.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = prep_flags.div_zero ? ST_FIX : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!core_running)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIX);
        end
    end

    // Flags of the operation in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= prep_flags;
        end
    end

    // Restore the signs and cut the results to the operation width.
    always_comb
    begin
        mask = flags_reg.narrow ? WORD_BITS'({ssd_pkg::NARROW_BITS{1'b1}}) : '1;
        quo_fixed = flags_reg.quo_neg ? (WORD_BITS'(0) - core_quotient) : core_quotient;
        rem_fixed = flags_reg.rem_neg ? (WORD_BITS'(0) - core_remainder) : core_remainder;
        quo_fixed = quo_fixed & mask;
        rem_fixed = rem_fixed & mask;
    end

    // Result register, loaded in the fixup cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIX)
        begin
            if (flags_reg.div_zero)
            begin
                result_reg.quotient  <= '0;
                result_reg.remainder <= '0;
            end
            else
            begin
                result_reg.quotient  <= 64'(quo_fixed);
                result_reg.remainder <= 64'(rem_fixed);
            end
            result_reg.divide_by_zero <= flags_reg.div_zero;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/ssd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker: port-level checks of the shift-subtract divider
// Watches the command and result ports over time and reports violations.
// ----------------------------------------------------------------------------
module ssd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ssd_pkg::result_t  result
);

    // An accepted request keeps the divider busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("divider not busy after an accepted transfer");

    // A result strobe is never followed directly by another one.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result transfers in consecutive cycles");

    // The divider is idle while it presents a result.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while the divider is busy");

    // A zero divisor gives zero quotient and remainder.
    a_zero_results: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |->
            (result.quotient == 64'd0 && result.remainder == 64'd0))
        else $error("nonzero results on a divide by zero");

endmodule

bind shift_subtract_divider ssd_checker u_ssd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[verif/ssd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_result_checker: result checker for the shift-subtract divider
// Watches the request and result channels of the divider. Each accepted
// request is run through a behavioral divide, and the predicted quotient,
// remainder and zero-divisor flag are queued. Each result strobe is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_result_checker #(
    parameter int WORD_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ssd_pkg::request_t request,
    input  logic              done,
    input  ssd_pkg::result_t  result,
    output int                mismatch_count,
    output int                outstanding
);

    // Width of the wide modes, held to the range the divider supports.
    localparam int WIDE_BITS = (WORD_BITS < ssd_pkg::NARROW_BITS) ? ssd_pkg::NARROW_BITS :
                               (WORD_BITS > 64) ? 64 : WORD_BITS;

    ssd_pkg::result_t predicted_divisions[$];

    // Behavioral divide: signed modes work on magnitudes, truncate toward
    // zero and give the remainder the sign of the dividend.
    function automatic ssd_pkg::result_t compute_division(input ssd_pkg::request_t req);
        int unsigned      width;
        logic             signed_op;
        logic             num_neg;
        logic             den_neg;
        logic [63:0]      mask;
        logic [63:0]      sign_bit;
        logic [63:0]      num;
        logic [63:0]      den;
        logic [63:0]      quo;
        logic [63:0]      rem;
        ssd_pkg::result_t res;
        width = (req.opcode == ssd_pkg::OP_UNSIGNED_NARROW ||
                 req.opcode == ssd_pkg::OP_SIGNED_NARROW) ? ssd_pkg::NARROW_BITS : WIDE_BITS;
        signed_op = (req.opcode == ssd_pkg::OP_SIGNED_WIDE ||
                     req.opcode == ssd_pkg::OP_SIGNED_NARROW);
        mask = (width >= 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
        sign_bit = 64'd1 << (width - 1);
        num = req.dividend & mask;
        den = req.divisor & mask;
        res = '0;
        // A zero divisor gives the error flag and zero results.
        if (den == 64'd0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        num_neg = signed_op && ((num & sign_bit) != 64'd0);
        den_neg = signed_op && ((den & sign_bit) != 64'd0);
        if (num_neg)
            num = (~num + 64'd1) & mask;
        if (den_neg)
            den = (~den + 64'd1) & mask;
        quo = num / den;
        rem = num % den;
        // The most negative value by minus one wraps back to itself here.
        if (num_neg != den_neg)
            quo = (~quo + 64'd1) & mask;
        if (num_neg)
            rem = (~rem + 64'd1) & mask;
        res.quotient  = quo & mask;
        res.remainder = rem & mask;
        return res;
    endfunction

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Compare each result transfer with the oldest prediction, then queue
    // the prediction for a request accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        ssd_pkg::result_t want;
        if (!rst_n)
        begin
            predicted_divisions.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_divisions.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", result.quotient, '0);
                end
                else
                begin
                    want = predicted_divisions.pop_front();
                    if (result.quotient !== want.quotient)
                        report_mismatch("quotient", result.quotient, want.quotient);
                    if (result.remainder !== want.remainder)
                        report_mismatch("remainder", result.remainder, want.remainder);
                    if (result.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", 64'(result.divide_by_zero),
                                        64'(want.divide_by_zero));
                end
            end
            if (start && !busy)
                predicted_divisions.push_back(compute_division(request));
            outstanding <= predicted_divisions.size();
        end
    end

endmodule

[verif/shift_subtract_divider_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_subtract_divider_tb: testbench of the shift-subtract divider
// Sends a directed set of divisions covering every mode, zero divisors,
// overflow and ignored upper bits, then random divisions in bursts with
// random gaps. A checker beside the divider predicts and compares results.
// ----------------------------------------------------------------------------
module shift_subtract_divider_tb;

    localparam int WORD_BITS     = 64;
    localparam int RANDOM_ITEMS  = 800;
    localparam int DRAIN_EVERY   = 200;
    localparam int SETTLE_CYCLES = WORD_BITS + 8;
    localparam int DRAIN_LIMIT   = 20 * (WORD_BITS + 2);
    localparam longint TIMEOUT_NS = 4_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    ssd_pkg::request_t request = '0;
    logic              busy;
    logic              done;
    ssd_pkg::result_t  result;
    int                mismatch_count;
    int                outstanding;

    shift_subtract_divider #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    ssd_result_checker #(
        .WORD_BITS (WORD_BITS)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic ssd_pkg::request_t make_request(input logic [1:0] op,
                                                       input logic [63:0] num,
                                                       input logic [63:0] den);
        ssd_pkg::request_t req;
        req.opcode   = op;
        req.dividend = num;
        req.divisor  = den;
        return req;
    endfunction

    // Operand with interesting content in its low bits: zero, one, minus
    // one, the most negative value, small values of either sign, full
    // random values and random magnitudes.
    function automatic logic [63:0] shaped_operand(input int unsigned bits);
        logic [63:0] mask;
        logic [63:0] value;
        mask = (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
        value = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       value = 64'd0;
            1:       value = 64'd1;
            2:       value = {64{1'b1}};
            3:       value = 64'd1 << (bits - 1);
            4:       value = 64'($urandom_range(1, 300));
            5:       value = ~64'($urandom_range(1, 300)) + 64'd1;
            6, 7:    value = value;
            default:
            begin
                value = value >> $urandom_range(0, bits - 1);
                if ($urandom_range(0, 1) == 1)
                    value = ~value + 64'd1;
            end
        endcase
        return value & mask;
    endfunction

    // Random division; narrow modes carry random bits above the low word.
    function automatic ssd_pkg::request_t random_request();
        logic [1:0]        op;
        logic              narrow;
        ssd_pkg::request_t req;
        op = 2'($urandom_range(0, 3));
        narrow = (op == ssd_pkg::OP_UNSIGNED_NARROW || op == ssd_pkg::OP_SIGNED_NARROW);
        req.opcode = op;
        if (narrow)
        begin
            req.dividend = {$urandom, 32'(shaped_operand(ssd_pkg::NARROW_BITS))};
            req.divisor  = {$urandom, 32'(shaped_operand(ssd_pkg::NARROW_BITS))};
        end
        else
        begin
            req.dividend = shaped_operand(64);
            req.divisor  = shaped_operand(64);
        end
        return req;
    endfunction

    // Holds start high until the divider takes the request.
    task automatic send_request(input ssd_pkg::request_t req);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Pauses the sender until every outstanding division has returned, or until the drain limit is reached.
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int sent;
        int burst;
        int gap;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed divisions.
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, 64'd100, 64'd7));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, {64{1'b1}}, 64'd1));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, {64{1'b1}}, {64{1'b1}}));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, 64'd5, 64'd0));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, 64'd3, 64'd10));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, 64'd0, 64'd9));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_WIDE, 64'h8000_0000_0000_0000,
                                  64'd3));
        send_request(make_request(ssd_pkg::OP_UNSIGNED_NARROW, 64'hDEAD_BEEF_FFFF_FFFF,
                                  64'h1234_5678_0000_0003));
        // Nonzero upper bits do not hide a zero narrow divisor.
        send_request(make_request(ssd_pkg::OP_UNSIGNED_NARROW, 64'h0000_0001_0000_0042,
                                  64'hFFFF_FFFF_0000_0000));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, -64'sd7, 64'd2));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, 64'd7, -64'sd2));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, -64'sd7, -64'sd2));
        // Most negative value by minus one, and by one.
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, 64'h8000_0000_0000_0000,
                                  {64{1'b1}}));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, 64'h8000_0000_0000_0000,
                                  64'd1));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, 64'h7FFF_FFFF_FFFF_FFFF,
                                  64'h8000_0000_0000_0000));
        send_request(make_request(ssd_pkg::OP_SIGNED_WIDE, 64'd0, 64'd0));
        send_request(make_request(ssd_pkg::OP_SIGNED_NARROW, 64'h5555_5555_8000_0000,
                                  64'hAAAA_AAAA_FFFF_FFFF));
        send_request(make_request(ssd_pkg::OP_SIGNED_NARROW, 64'hFFFF_0000_FFFF_FF9C,
                                  64'h0000_FFFF_0000_0007));
        send_request(make_request(ssd_pkg::OP_SIGNED_NARROW, 64'h0000_0000_0000_0064,
                                  64'h0000_0000_FFFF_FFF9));
        send_request(make_request(ssd_pkg::OP_SIGNED_NARROW, 64'hFFFF_FFFF_7FFF_FFFF,
                                  64'h0000_0001_0000_0000));
        wait_drained();

        // Random divisions in bursts, with the sender drained now and then.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                send_request(random_request());
                sent++;
                if (sent % DRAIN_EVERY == 0)
                    wait_drained();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // Let the last results arrive, then give the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/ssd_pkg.sv
hdl/ssd_operand_prep.sv
hdl/ssd_shift_core.sv
hdl/shift_subtract_divider.sv
hdl/ssd_checker.sv
verif/ssd_checker.sv
verif/shift_subtract_divider_tb.sv
